### hdl/finite_ring_invariant_analyzer_unit_assert.svh
// Assertion macros for the ring analyzer.
`ifndef FINITE_RING_INVARIANT_ANALYZER_UNIT_ASSERT_SVH
`define FINITE_RING_INVARIANT_ANALYZER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define FRIA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ring analyzer assertion failed");

// Next-cycle implication.
`define FRIA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ring analyzer assertion failed");

`endif

### hdl/fria_pkg.sv
package fria_pkg;

    localparam logic [4:0] RING_ORDER_RESET = 5'd4;

    typedef struct packed {
        logic [4:0] entry_value;
        logic       start_of_tables;
    } t_in_req;

    typedef struct packed {
        logic [4:0]  max_additive_order;
        logic        is_commutative;
        logic        has_unity;
        logic [4:0]  noninvertible_count;
        logic [4:0]  idempotent_count;
        logic [3:0]  square_zero_count;
        logic [3:0]  cube_zero_count;
        logic [8:0]  zero_product_count;
        logic [3:0]  zero_divisor_count;
        logic [4:0]  center_size;
        logic [15:0] center_mask;
        logic        table_fault;
    } t_result;

endpackage

### hdl/fria_ram.sv
module fria_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### hdl/finite_ring_invariant_analyzer_unit.sv
// Finite ring invariant analyzer.
// Requests: one table entry per request, taken when start is high and busy low.
// The addition table comes first, then the multiplication table, row-major,
// entries 1-based; start_of_tables marks the first entry and restarts loading.
// Once the last of the 2*n*n entries is in, busy stays high while one
// sequencer sweeps the tables through the RAM read ports: the additive orders
// (each add-table read split into a request and a response state), the divisor
// search over all d, then the pair pass, the cube pass and the inverse pass
// (skipped when there is no unity), after which o_result_strobe is high for
// one cycle and the result stays on o_result until a new result replaces it.
// The receiver cannot stall. A write to ring_order (i_cfg_we) sets n; when it
// comes while idle and no entry is taken, the write position is then recomputed
// by subtraction in S_LOCATE, busy high. Reset (synchronous) sets n to 4 and
// clears the load position; table contents are undefined until loaded.
module finite_ring_invariant_analyzer_unit #(
    parameter int MAX_ELEMENTS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  fria_pkg::t_in_req i_req,
    input  logic              i_cfg_we,
    input  logic [4:0]        i_cfg_wdata,
    output fria_pkg::t_result o_result,
    output logic              o_result_strobe
);

    import fria_pkg::*;

    localparam int EW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int NW = $clog2(MAX_ELEMENTS + 1);
    localparam int DEPTH = MAX_ELEMENTS * MAX_ELEMENTS;
    localparam int AW = $clog2(DEPTH);
    localparam int PW = $clog2(2 * DEPTH + 1);
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [8:0] {
        S_LOAD   = 9'b000000001,
        S_LOCATE = 9'b000000010,
        S_AREQ   = 9'b000000100,
        S_ARSP   = 9'b000001000,
        S_DIV    = 9'b000010000,
        S_PAIR   = 9'b000100000,
        S_CUBE   = 9'b001000000,
        S_INV    = 9'b010000000,
        S_OUT    = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        PH_ADD  = 2'd0,
        PH_MUL  = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    function automatic logic [NW-1:0] f_clamp(logic [4:0] v);
        if (v == 5'd0) begin
            return NW'(1);
        end else if (32'(v) > MAX_ELEMENTS) begin
            return NW'(MAX_ELEMENTS);
        end
        return NW'(v);
    endfunction

    function automatic logic [AW-1:0] f_addr(logic [EW-1:0] r, logic [EW-1:0] c);
        return AW'(32'(r) * MAX_ELEMENTS + 32'(c));
    endfunction

    function automatic t_phase f_next_phase(t_phase p);
        unique case (p)
            PH_ADD:  return PH_MUL;
            default: return PH_DONE;
        endcase
    endfunction

    t_state  r_state, n_state;
    logic [NW-1:0] r_n;
    logic [PW-1:0] r_pos, n_pos, r_rem, n_rem;
    logic [EW-1:0] r_row, n_row, r_col, n_col;
    t_phase  r_phase, n_phase;
    logic    r_rfault, n_rfault, r_afault, n_afault;
    logic [EW-1:0] r_x, n_x, r_y, n_y, r_px, n_px, r_py, n_py, r_t, n_t;
    logic    r_idone, n_idone, r_pv, n_pv;
    logic [NW-1:0] r_i, n_i, r_d, n_d, r_max, n_max;
    logic [NW:0] r_m, n_m;
    logic [MAX_ELEMENTS:0] r_seen, n_seen;
    logic    r_comm, n_comm, r_found, n_found;
    logic [EW-1:0] r_unity, n_unity;
    logic [NW-1:0] r_noninv, n_noninv, r_idem, n_idem, r_sq0, n_sq0, r_cb0, n_cb0;
    logic [NW-1:0] r_zdiv, n_zdiv, r_csize, n_csize;
    logic [CW-1:0] r_zprod, n_zprod;
    logic [15:0] r_cmask, n_cmask;
    logic    r_row_ok, n_row_ok, r_row_cen, n_row_cen;
    logic    r_row_zd, n_row_zd, r_row_inv, n_row_inv;
    logic [EW-1:0] r_diag [MAX_ELEMENTS];
    logic    r_strobe, n_strobe;
    t_result r_result, n_result;

    logic          w_accept, w_inrange, w_fault1, w_add_we, w_mul_we, w_diag_we;
    logic          w_ok_f, w_cen_f, w_zd_f, w_inv_f;
    logic [PW-1:0] w_pos0, w_pos1, w_sq, w_sq2;
    logic [EW-1:0] w_row0, w_col0, w_stored, w_last_e, w_a, w_b, w_add_rdata;
    logic [AW-1:0] w_waddr, w_add_raddr, w_mula_raddr, w_mulb_raddr;
    t_phase        w_phase0;

    assign busy     = (r_state != S_LOAD);
    assign w_accept = start && !busy;
    assign w_sq     = PW'(r_n) * PW'(r_n);
    assign w_sq2    = PW'({w_sq, 1'b0});
    assign w_last_e = EW'(r_n - NW'(1));
    assign w_pos0   = i_req.start_of_tables ? '0 : r_pos;
    assign w_row0   = i_req.start_of_tables ? '0 : r_row;
    assign w_col0   = i_req.start_of_tables ? '0 : r_col;
    assign w_phase0 = i_req.start_of_tables ? PH_ADD : r_phase;
    assign w_pos1   = w_pos0 + PW'(1);
    assign w_inrange = (i_req.entry_value != 5'd0) &&
                       ({1'b0, i_req.entry_value} <= 6'(r_n));
    assign w_stored = w_inrange ? EW'(i_req.entry_value - 5'd1) : '0;
    assign w_fault1 = (i_req.start_of_tables ? 1'b0 : r_rfault) | !w_inrange;
    assign w_waddr  = f_addr(w_row0, w_col0);

    assign w_add_raddr  = f_addr(r_t, r_x);
    assign w_mula_raddr = (r_state == S_CUBE) ? f_addr(r_diag[r_x], r_x) : f_addr(r_x, r_y);
    assign w_mulb_raddr = f_addr(r_y, r_x);

    fria_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_add_ram (
        .i_clk   (i_clk),
        .i_we    (w_add_we),
        .i_waddr (w_waddr),
        .i_wdata (w_stored),
        .i_raddr (w_add_raddr),
        .o_rdata (w_add_rdata)
    );

    fria_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_mula_ram (
        .i_clk   (i_clk),
        .i_we    (w_mul_we),
        .i_waddr (w_waddr),
        .i_wdata (w_stored),
        .i_raddr (w_mula_raddr),
        .o_rdata (w_a)
    );

    // duplicate copy gives the transposed read
    fria_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_mulb_ram (
        .i_clk   (i_clk),
        .i_we    (w_mul_we),
        .i_waddr (w_waddr),
        .i_wdata (w_stored),
        .i_raddr (w_mulb_raddr),
        .o_rdata (w_b)
    );

    assign w_ok_f  = r_row_ok && (w_a == r_py) && (w_b == r_py);
    assign w_cen_f = r_row_cen && (w_a == w_b);
    assign w_zd_f  = r_row_zd || ((r_px != '0) && (r_py != '0) && (w_a == '0));
    assign w_inv_f = r_row_inv || ((w_a == r_unity) && (w_b == r_unity));

    always_comb begin
        n_state = r_state;  n_pos = r_pos;     n_rem = r_rem;
        n_row = r_row;      n_col = r_col;     n_phase = r_phase;
        n_rfault = r_rfault; n_afault = r_afault;
        n_x = r_x;  n_y = r_y;  n_px = r_x;  n_py = r_y;  n_t = r_t;
        n_idone = r_idone;  n_pv = 1'b0;
        n_i = r_i;  n_d = r_d;  n_m = r_m;  n_max = r_max;  n_seen = r_seen;
        n_comm = r_comm;    n_found = r_found; n_unity = r_unity;
        n_noninv = r_noninv; n_idem = r_idem;  n_sq0 = r_sq0;  n_cb0 = r_cb0;
        n_zdiv = r_zdiv;    n_csize = r_csize; n_zprod = r_zprod; n_cmask = r_cmask;
        n_row_ok = r_row_ok; n_row_cen = r_row_cen;
        n_row_zd = r_row_zd; n_row_inv = r_row_inv;
        n_strobe = 1'b0;    n_result = r_result;
        w_add_we = 1'b0;    w_mul_we = 1'b0;   w_diag_we = 1'b0;

        unique case (r_state)
            S_LOAD: begin
                if (w_accept) begin
                    w_add_we = (w_phase0 == PH_ADD);
                    w_mul_we = (w_phase0 == PH_MUL);
                    if (w_pos1 >= w_sq2) begin
                        n_state = S_AREQ;
                        n_pos = '0;  n_row = '0;  n_col = '0;  n_phase = PH_ADD;
                        n_rfault = 1'b0;  n_afault = w_fault1;
                        n_x = '0;  n_t = '0;  n_i = NW'(1);  n_seen = '0;  n_max = '0;
                        n_comm = 1'b1;  n_found = 1'b0;  n_unity = '0;
                        n_noninv = '0;  n_idem = '0;  n_sq0 = '0;  n_cb0 = '0;
                        n_zdiv = '0;  n_csize = '0;  n_zprod = '0;  n_cmask = '0;
                    end else begin
                        n_pos = w_pos1;
                        n_rfault = w_fault1;
                        n_row = w_row0;
                        n_phase = w_phase0;
                        if (w_col0 == w_last_e) begin
                            n_col = '0;
                            if (w_row0 == w_last_e) begin
                                n_row = '0;
                                n_phase = f_next_phase(w_phase0);
                            end else begin
                                n_row = w_row0 + EW'(1);
                            end
                        end else begin
                            n_col = w_col0 + EW'(1);
                        end
                    end
                end else if (i_cfg_we) begin
                    n_state = S_LOCATE;
                    n_rem = r_pos;  n_row = '0;  n_col = '0;  n_phase = PH_ADD;
                end
            end
            S_LOCATE: begin
                if (i_cfg_we) begin
                    n_rem = r_pos;  n_row = '0;  n_col = '0;  n_phase = PH_ADD;
                end else if (r_phase != PH_DONE && r_rem >= w_sq) begin
                    n_rem = r_rem - w_sq;
                    n_phase = f_next_phase(r_phase);
                end else if (r_phase == PH_DONE) begin
                    n_state = S_LOAD;
                end else if (r_rem >= PW'(r_n)) begin
                    n_rem = r_rem - PW'(r_n);
                    n_row = r_row + EW'(1);
                end else begin
                    n_col = EW'(r_rem);
                    n_state = S_LOAD;
                end
            end
            S_AREQ: begin
                n_state = S_ARSP;
            end
            S_ARSP: begin
                if (w_add_rdata != '0 && r_i != r_n) begin
                    n_i = r_i + NW'(1);
                    n_t = w_add_rdata;
                    n_state = S_AREQ;
                end else begin
                    if (w_add_rdata == '0) begin
                        n_seen[r_i] = 1'b1;
                    end else begin
                        n_afault = 1'b1;
                    end
                    if (r_x == w_last_e) begin
                        n_state = S_DIV;
                        n_d = NW'(1);
                        n_m = (NW + 1)'(1);
                    end else begin
                        n_x = r_x + EW'(1);
                        n_t = '0;
                        n_i = NW'(1);
                        n_state = S_AREQ;
                    end
                end
            end
            S_DIV: begin
                if (r_m < {1'b0, r_n}) begin
                    n_m = r_m + (NW + 1)'(r_d);
                end else begin
                    if (r_m == {1'b0, r_n} && r_seen[r_d]) begin
                        n_max = r_d;
                    end
                    if (r_d == r_n) begin
                        n_state = S_PAIR;
                        n_x = '0;  n_y = '0;  n_idone = 1'b0;
                        n_row_ok = 1'b1;  n_row_cen = 1'b1;  n_row_zd = 1'b0;
                    end else begin
                        n_d = r_d + NW'(1);
                        n_m = (NW + 1)'(r_d) + (NW + 1)'(1);
                    end
                end
            end
            S_PAIR, S_INV: begin
                if (r_state == S_INV && !r_found) begin
                    n_noninv = r_n;
                    n_state = S_OUT;
                end else begin
                    if (!r_idone) begin
                        n_pv = 1'b1;
                        if (r_y == w_last_e) begin
                            n_y = '0;
                            if (r_x == w_last_e) begin
                                n_idone = 1'b1;
                            end else begin
                                n_x = r_x + EW'(1);
                            end
                        end else begin
                            n_y = r_y + EW'(1);
                        end
                    end
                    if (r_pv && r_state == S_PAIR) begin
                        n_row_ok = w_ok_f;  n_row_cen = w_cen_f;  n_row_zd = w_zd_f;
                        if (w_a != w_b) begin
                            n_comm = 1'b0;
                        end
                        if (w_a == '0) begin
                            n_zprod = r_zprod + CW'(1);
                        end
                        if (r_px == r_py) begin
                            w_diag_we = 1'b1;
                            if (w_a == r_px) begin
                                n_idem = r_idem + NW'(1);
                            end
                            if (r_px != '0 && w_a == '0) begin
                                n_sq0 = r_sq0 + NW'(1);
                            end
                        end
                        if (r_py == w_last_e) begin
                            n_row_ok = 1'b1;  n_row_cen = 1'b1;  n_row_zd = 1'b0;
                            if (w_ok_f && !r_found) begin
                                n_found = 1'b1;
                                n_unity = r_px;
                            end
                            if (w_cen_f) begin
                                n_csize = r_csize + NW'(1);
                                if (32'(r_px) < 16) begin
                                    n_cmask = r_cmask | (16'd1 << r_px);
                                end
                            end
                            if (w_zd_f) begin
                                n_zdiv = r_zdiv + NW'(1);
                            end
                            if (r_px == w_last_e) begin
                                n_x = (r_n == NW'(1)) ? '0 : EW'(1);
                                n_y = '0;  n_idone = 1'b0;  n_row_inv = 1'b0;
                                n_state = (r_n == NW'(1)) ? S_INV : S_CUBE;
                            end
                        end
                    end
                    if (r_pv && r_state == S_INV) begin
                        n_row_inv = w_inv_f;
                        if (r_py == w_last_e) begin
                            n_row_inv = 1'b0;
                            if (!w_inv_f) begin
                                n_noninv = r_noninv + NW'(1);
                            end
                            if (r_px == w_last_e) begin
                                n_state = S_OUT;
                            end
                        end
                    end
                end
            end
            S_CUBE: begin
                if (!r_idone) begin
                    n_pv = 1'b1;
                    if (r_x == w_last_e) begin
                        n_idone = 1'b1;
                    end else begin
                        n_x = r_x + EW'(1);
                    end
                end
                if (r_pv) begin
                    if (w_a == '0) begin
                        n_cb0 = r_cb0 + NW'(1);
                    end
                    if (r_px == w_last_e) begin
                        n_x = '0;  n_y = '0;  n_idone = 1'b0;  n_row_inv = 1'b0;
                        n_state = S_INV;
                    end
                end
            end
            S_OUT: begin
                n_state = S_LOAD;
                n_strobe = 1'b1;
                n_result.max_additive_order  = 5'(r_max);
                n_result.is_commutative      = r_comm;
                n_result.has_unity           = r_found;
                n_result.noninvertible_count = 5'(r_noninv);
                n_result.idempotent_count    = 5'(r_idem);
                n_result.square_zero_count   = 4'(r_sq0);
                n_result.cube_zero_count     = 4'(r_cb0);
                n_result.zero_product_count  = 9'(r_zprod);
                n_result.zero_divisor_count  = 4'(r_zdiv);
                n_result.center_size         = 5'(r_csize);
                n_result.center_mask         = r_cmask;
                n_result.table_fault         = r_afault;
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_n      <= f_clamp(RING_ORDER_RESET);
            r_pos    <= '0;
            r_row    <= '0;
            r_col    <= '0;
            r_phase  <= PH_ADD;
            r_rfault <= 1'b0;
            r_idone  <= 1'b0;
            r_pv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            if (i_cfg_we) begin
                r_n <= f_clamp(i_cfg_wdata);
            end
            r_pos    <= n_pos;
            r_row    <= n_row;
            r_col    <= n_col;
            r_phase  <= n_phase;
            r_rfault <= n_rfault;
            r_idone  <= n_idone;
            r_pv     <= n_pv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;  r_afault <= n_afault;
        r_x <= n_x;  r_y <= n_y;  r_px <= n_px;  r_py <= n_py;  r_t <= n_t;
        r_i <= n_i;  r_d <= n_d;  r_m <= n_m;  r_max <= n_max;  r_seen <= n_seen;
        r_comm <= n_comm;  r_found <= n_found;  r_unity <= n_unity;
        r_noninv <= n_noninv;  r_idem <= n_idem;  r_sq0 <= n_sq0;  r_cb0 <= n_cb0;
        r_zdiv <= n_zdiv;  r_csize <= n_csize;  r_zprod <= n_zprod;  r_cmask <= n_cmask;
        r_row_ok <= n_row_ok;  r_row_cen <= n_row_cen;
        r_row_zd <= n_row_zd;  r_row_inv <= n_row_inv;
        r_result <= n_result;
        if (w_diag_we) begin
            r_diag[r_px] <= w_a;
        end
    end

    assign o_result        = r_result;
    assign o_result_strobe = r_strobe;

`include "finite_ring_invariant_analyzer_unit_assert.svh"

    `FRIA_ASSERT_NOW(a_no_write_in_analysis, r_state != S_LOAD, !w_add_we && !w_mul_we)
    `FRIA_ASSERT_NOW(a_strobe_after_busy, o_result_strobe, $past(busy) && !busy)
    `FRIA_ASSERT_NOW(a_no_unity_count, o_result_strobe && !o_result.has_unity,
                     o_result.noninvertible_count == 5'(r_n))

endmodule
